// ----- rtl/cascaded_position_velocity_pid_macros.svh -----
// Assertion macros shared by the cascaded position/velocity controller.
// No dependencies; included by cpvp_ctrl, the module that carries assertions.
`ifndef CASCADED_POSITION_VELOCITY_PID_MACROS_SVH
`define CASCADED_POSITION_VELOCITY_PID_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CPVP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant violated");

// Same-cycle implication.
`define CPVP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Next-cycle implication.
`define CPVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

// ----- rtl/cpvp_pkg.sv -----
// Shared widths, constants, register indexes and interface structs
// for the cascaded position/velocity controller. No dependencies.
package cpvp_pkg;

    localparam int ANGLE_W     = 9;
    localparam int SPEED_W     = 16;
    localparam int TARGET_W    = 24;
    localparam int GAIN_W      = 20;
    localparam int LIMIT_W     = 15;
    localparam int OFFSET_W    = 24;
    localparam int TURN_W      = 24;
    localparam int ERR_W       = 32;
    localparam int EV_W        = 18;
    localparam int VSUM_W      = 15;
    localparam int OUT_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int ACC_W       = 56;
    localparam int GAIN_FRAC   = 8;
    localparam int MAC_CNT_W   = $clog2(GAIN_W);

    localparam int HALF_TURN     = 180;
    localparam int FULL_TURN     = 360;
    localparam int VEL_SUM_LIMIT = 10000;

    localparam int POS_KP_RST      = 25600;
    localparam int POS_KI_RST      = 0;
    localparam int POS_KD_RST      = 2560;
    localparam int VEL_KP_RST      = 2560;
    localparam int VEL_KI_RST      = 0;
    localparam int VEL_KD_RST      = 0;
    localparam int DRIVE_LIMIT_RST = 30000;
    localparam int ZERO_OFFSET_RST = 0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POS_KP      = 3'd0,
        REG_POS_KI      = 3'd1,
        REG_POS_KD      = 3'd2,
        REG_VEL_KP      = 3'd3,
        REG_VEL_KI      = 3'd4,
        REG_VEL_KD      = 3'd5,
        REG_DRIVE_LIMIT = 3'd6,
        REG_ZERO_OFFSET = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        [GAIN_W-1:0]   pos_kp;
        logic        [GAIN_W-1:0]   pos_ki;
        logic        [GAIN_W-1:0]   pos_kd;
        logic        [GAIN_W-1:0]   vel_kp;
        logic        [GAIN_W-1:0]   vel_ki;
        logic        [GAIN_W-1:0]   vel_kd;
        logic        [LIMIT_W-1:0]  drive_limit;
        logic signed [OFFSET_W-1:0] zero_offset;
    } cfg_t;

    typedef struct packed {
        logic        [ANGLE_W-1:0]  raw_angle;
        logic signed [SPEED_W-1:0]  measured_speed;
        logic signed [TARGET_W-1:0] target_angle;
        logic                       hold_reset;
    } item_t;

    typedef struct packed {
        logic                    busy;
        logic                    res_valid;
        logic signed [OUT_W-1:0] drive_value;
        logic                    drive_enable;
    } ctrl_sts_t;

    typedef struct packed {
        logic                    start;
        logic                    clear;
        logic signed [ACC_W-1:0] operand;
        logic        [GAIN_W-1:0] gain;
    } mac_cmd_t;

    typedef struct packed {
        logic                    busy;
        logic signed [ACC_W-1:0] acc;
    } mac_sts_t;

endpackage

// ----- rtl/cpvp_mac.sv -----
// Serial multiply-accumulate unit: one gain bit per cycle, shift-and-add.
// Depends on cpvp_pkg.
module cpvp_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  cpvp_pkg::mac_cmd_t  cmd,
    output cpvp_pkg::mac_sts_t  sts
);

    logic                                 busy_reg;
    logic        [cpvp_pkg::MAC_CNT_W-1:0] cnt_reg;
    logic signed [cpvp_pkg::ACC_W-1:0]    mcand_reg;
    logic        [cpvp_pkg::GAIN_W-1:0]   gain_reg;
    logic signed [cpvp_pkg::ACC_W-1:0]    acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + cpvp_pkg::MAC_CNT_W'(1);
            if (cnt_reg == cpvp_pkg::MAC_CNT_W'(cpvp_pkg::GAIN_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The gain shifts out LSB first while the multiplicand doubles each cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mcand_reg <= cmd.operand;
            gain_reg  <= cmd.gain;
            if (cmd.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (gain_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= mcand_reg <<< 1;
            gain_reg  <= gain_reg >> 1;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.acc  = acc_reg;

endmodule

// ----- rtl/cpvp_ctrl.sv -----
// Sequencer for one control tick: angle unwrap, position PID, velocity PID.
// Depends on cpvp_pkg and the assertion macros; drives the serial MAC unit.
`include "cascaded_position_velocity_pid_macros.svh"

module cpvp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cpvp_pkg::item_t      item,
    input  cpvp_pkg::cfg_t       cfg,
    input  logic                 res_take,
    output cpvp_pkg::ctrl_sts_t  sts,
    output cpvp_pkg::mac_cmd_t   mac_cmd,
    input  cpvp_pkg::mac_sts_t   mac_sts
);

    localparam int ANG_DIFF_W = cpvp_pkg::ANGLE_W + 1;
    localparam int POS_W      = cpvp_pkg::ERR_W + 2;
    localparam int EDIFF_W    = POS_W + 1;
    localparam int DIFF_W     = cpvp_pkg::ERR_W + 1;
    localparam int VD_W       = cpvp_pkg::EV_W + 1;
    localparam int Q_W        = cpvp_pkg::ACC_W - cpvp_pkg::GAIN_FRAC;

    localparam logic signed [ANG_DIFF_W-1:0] HALF_S =
        ANG_DIFF_W'(cpvp_pkg::HALF_TURN);
    localparam logic signed [cpvp_pkg::TURN_W-1:0] TURN_ONE = cpvp_pkg::TURN_W'(1);
    localparam logic signed [VD_W-1:0] VS_HI = VD_W'(cpvp_pkg::VEL_SUM_LIMIT);
    localparam logic signed [VD_W-1:0] VS_LO = -VS_HI;

    typedef enum logic [3:0] {
        S_IDLE, S_TURN, S_TURN_WAIT, S_ERR, S_SUM, S_MAC, S_MAC_WAIT,
        S_DIV, S_CLAMP, S_VEL, S_VSUM, S_DONE
    } state_t;

    typedef enum logic {PH_POS, PH_VEL} phase_t;

    typedef enum logic [1:0] {TERM_P, TERM_I, TERM_D} term_t;

    state_t state_reg;
    phase_t phase_reg;
    term_t  term_reg;

    logic        [cpvp_pkg::ANGLE_W-1:0]  raw_reg;
    logic signed [cpvp_pkg::SPEED_W-1:0]  speed_reg;
    logic signed [cpvp_pkg::TARGET_W-1:0] target_reg;
    logic                                 hold_reg;

    logic        [cpvp_pkg::ANGLE_W-1:0]  angle_now_reg;
    logic        [cpvp_pkg::ANGLE_W-1:0]  angle_before_reg;
    logic signed [cpvp_pkg::TURN_W-1:0]   turn_count_reg;
    logic signed [cpvp_pkg::ERR_W-1:0]    pos_error_prev_reg;
    logic signed [cpvp_pkg::ERR_W-1:0]    pos_error_sum_reg;
    logic signed [cpvp_pkg::EV_W-1:0]     vel_error_prev_reg;
    logic signed [cpvp_pkg::VSUM_W-1:0]   vel_error_sum_reg;

    logic signed [POS_W-1:0]              pos_reg;
    logic signed [cpvp_pkg::ERR_W-1:0]    e_reg;
    logic signed [DIFF_W-1:0]             d_reg;
    logic signed [Q_W-1:0]                q_reg;
    logic signed [cpvp_pkg::OUT_W-1:0]    loop_out_reg;
    logic signed [cpvp_pkg::EV_W-1:0]     ev_reg;
    logic signed [VD_W-1:0]               vd_reg;

    logic signed [ANG_DIFF_W-1:0]         ang_diff;
    logic signed [cpvp_pkg::TURN_W-1:0]   turn_next;
    logic signed [POS_W-1:0]              pos_calc;
    logic signed [EDIFF_W-1:0]            e_calc;
    logic signed [DIFF_W-1:0]             sum_calc;
    logic signed [DIFF_W-1:0]             d_calc;
    logic                                 round_up;
    logic signed [Q_W-1:0]                q_calc;
    logic signed [Q_W-1:0]                lim_pos_q;
    logic signed [Q_W-1:0]                lim_neg_q;
    logic signed [cpvp_pkg::OUT_W-1:0]    clamp_calc;
    logic signed [cpvp_pkg::EV_W-1:0]     ev_calc;
    logic signed [VD_W-1:0]               vs_calc;
    logic signed [cpvp_pkg::VSUM_W-1:0]   vs_clamped;
    logic signed [VD_W-1:0]               vd_calc;

    // Saturates a wide signed value to the 32-bit error range.
    function automatic logic signed [cpvp_pkg::ERR_W-1:0] sat_err(
        input logic signed [EDIFF_W-1:0] x
    );
        logic [EDIFF_W-cpvp_pkg::ERR_W:0] top;
        top = x[EDIFF_W-1:cpvp_pkg::ERR_W-1];
        if (top == '0 || top == '1)
        begin
            return x[cpvp_pkg::ERR_W-1:0];
        end
        else if (x[EDIFF_W-1])
        begin
            return {1'b1, {(cpvp_pkg::ERR_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(cpvp_pkg::ERR_W-1){1'b1}}};
        end
    endfunction

    // A jump of more than half a turn between samples means the shaft wrapped.
    assign ang_diff = $signed({1'b0, angle_now_reg}) - $signed({1'b0, angle_before_reg});

    always_comb
    begin
        if (ang_diff > HALF_S)
        begin
            turn_next = turn_count_reg - TURN_ONE;
        end
        else if (ang_diff < -HALF_S)
        begin
            turn_next = turn_count_reg + TURN_ONE;
        end
        else
        begin
            turn_next = turn_count_reg;
        end
    end

    assign pos_calc = $signed(mac_sts.acc[POS_W-1:0])
                    + $signed(POS_W'({1'b0, angle_now_reg}))
                    - POS_W'(cfg.zero_offset);
    assign e_calc   = EDIFF_W'(target_reg) - EDIFF_W'(pos_reg);
    assign sum_calc = DIFF_W'(pos_error_sum_reg) + DIFF_W'(e_reg);
    assign d_calc   = DIFF_W'(e_reg) - DIFF_W'(pos_error_prev_reg);

    // Division by 256 truncating toward zero: bump negative values with a fraction.
    assign round_up = mac_sts.acc[cpvp_pkg::ACC_W-1]
                    && (mac_sts.acc[cpvp_pkg::GAIN_FRAC-1:0] != '0);
    assign q_calc   = $signed(mac_sts.acc[cpvp_pkg::ACC_W-1:cpvp_pkg::GAIN_FRAC]
                              + Q_W'(round_up));

    assign lim_pos_q = $signed(Q_W'({1'b0, cfg.drive_limit}));
    assign lim_neg_q = -lim_pos_q;

    always_comb
    begin
        if (q_reg > lim_pos_q)
        begin
            clamp_calc = lim_pos_q[cpvp_pkg::OUT_W-1:0];
        end
        else if (q_reg < lim_neg_q)
        begin
            clamp_calc = lim_neg_q[cpvp_pkg::OUT_W-1:0];
        end
        else
        begin
            clamp_calc = q_reg[cpvp_pkg::OUT_W-1:0];
        end
    end

    assign ev_calc = cpvp_pkg::EV_W'(loop_out_reg) - cpvp_pkg::EV_W'(speed_reg);
    assign vs_calc = VD_W'(vel_error_sum_reg) + VD_W'(ev_reg);
    assign vd_calc = VD_W'(ev_reg) - VD_W'(vel_error_prev_reg);

    always_comb
    begin
        if (vs_calc > VS_HI)
        begin
            vs_clamped = VS_HI[cpvp_pkg::VSUM_W-1:0];
        end
        else if (vs_calc < VS_LO)
        begin
            vs_clamped = VS_LO[cpvp_pkg::VSUM_W-1:0];
        end
        else
        begin
            vs_clamped = vs_calc[cpvp_pkg::VSUM_W-1:0];
        end
    end

    // MAC command: the turn multiply by 360, then three gain terms per loop.
    always_comb
    begin
        mac_cmd.start   = (state_reg == S_TURN) || (state_reg == S_MAC);
        mac_cmd.clear   = (state_reg == S_TURN) || (term_reg == TERM_P);
        mac_cmd.operand = cpvp_pkg::ACC_W'(turn_next);
        mac_cmd.gain    = cpvp_pkg::GAIN_W'(cpvp_pkg::FULL_TURN);
        if (state_reg == S_MAC)
        begin
            unique case (term_reg)
                TERM_P:
                begin
                    mac_cmd.operand = (phase_reg == PH_POS) ?
                        cpvp_pkg::ACC_W'(e_reg) : cpvp_pkg::ACC_W'(ev_reg);
                    mac_cmd.gain = (phase_reg == PH_POS) ? cfg.pos_kp : cfg.vel_kp;
                end
                TERM_I:
                begin
                    mac_cmd.operand = (phase_reg == PH_POS) ?
                        cpvp_pkg::ACC_W'(pos_error_sum_reg) :
                        cpvp_pkg::ACC_W'(vel_error_sum_reg);
                    mac_cmd.gain = (phase_reg == PH_POS) ? cfg.pos_ki : cfg.vel_ki;
                end
                TERM_D:
                begin
                    mac_cmd.operand = (phase_reg == PH_POS) ?
                        cpvp_pkg::ACC_W'(d_reg) : cpvp_pkg::ACC_W'(vd_reg);
                    mac_cmd.gain = (phase_reg == PH_POS) ? cfg.pos_kd : cfg.vel_kd;
                end
                default:
                begin
                    mac_cmd.operand = '0;
                    mac_cmd.gain    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            phase_reg          <= PH_POS;
            term_reg           <= TERM_P;
            raw_reg            <= '0;
            speed_reg          <= '0;
            target_reg         <= '0;
            hold_reg           <= 1'b0;
            angle_now_reg      <= '0;
            angle_before_reg   <= '0;
            turn_count_reg     <= '0;
            pos_error_prev_reg <= '0;
            pos_error_sum_reg  <= '0;
            vel_error_prev_reg <= '0;
            vel_error_sum_reg  <= '0;
            pos_reg            <= '0;
            e_reg              <= '0;
            d_reg              <= '0;
            q_reg              <= '0;
            loop_out_reg       <= '0;
            ev_reg             <= '0;
            vd_reg             <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        raw_reg    <= item.raw_angle;
                        speed_reg  <= item.measured_speed;
                        target_reg <= item.hold_reset ? '0 : item.target_angle;
                        hold_reg   <= item.hold_reset;
                        state_reg  <= S_TURN;
                    end
                end
                S_TURN:
                begin
                    turn_count_reg <= turn_next;
                    state_reg      <= S_TURN_WAIT;
                end
                S_TURN_WAIT:
                begin
                    if (!mac_sts.busy)
                    begin
                        pos_reg   <= pos_calc;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    e_reg     <= sat_err(e_calc);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    pos_error_sum_reg  <= sat_err(EDIFF_W'(sum_calc));
                    d_reg              <= d_calc;
                    pos_error_prev_reg <= e_reg;
                    phase_reg          <= PH_POS;
                    term_reg           <= TERM_P;
                    state_reg          <= S_MAC;
                end
                S_MAC:
                begin
                    state_reg <= S_MAC_WAIT;
                end
                S_MAC_WAIT:
                begin
                    if (!mac_sts.busy)
                    begin
                        unique case (term_reg)
                            TERM_P:
                            begin
                                term_reg  <= TERM_I;
                                state_reg <= S_MAC;
                            end
                            TERM_I:
                            begin
                                term_reg  <= TERM_D;
                                state_reg <= S_MAC;
                            end
                            default:
                            begin
                                term_reg  <= TERM_P;
                                state_reg <= S_DIV;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    q_reg     <= q_calc;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    loop_out_reg <= clamp_calc;
                    if (phase_reg == PH_POS)
                    begin
                        state_reg <= S_VEL;
                    end
                    else
                    begin
                        // The new sample only takes effect on the next tick.
                        angle_before_reg <= angle_now_reg;
                        angle_now_reg    <= raw_reg;
                        state_reg        <= S_DONE;
                    end
                end
                S_VEL:
                begin
                    ev_reg    <= ev_calc;
                    state_reg <= S_VSUM;
                end
                S_VSUM:
                begin
                    vel_error_sum_reg  <= vs_clamped;
                    vd_reg             <= vd_calc;
                    vel_error_prev_reg <= ev_reg;
                    phase_reg          <= PH_VEL;
                    term_reg           <= TERM_P;
                    state_reg          <= S_MAC;
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sts.busy         = (state_reg != S_IDLE);
    assign sts.res_valid    = (state_reg == S_DONE);
    assign sts.drive_value  = hold_reg ? '0 : loop_out_reg;
    assign sts.drive_enable = !hold_reg;

    `CPVP_ASSERT_ALWAYS(a_vsum_range, clk, rst_n,
        (VD_W'(vel_error_sum_reg) <= VS_HI) && (VD_W'(vel_error_sum_reg) >= VS_LO))
    `CPVP_ASSERT_IMPL(a_mac_free_on_issue, clk, rst_n, mac_cmd.start, !mac_sts.busy)
    `CPVP_ASSERT_IMPL(a_start_only_idle, clk, rst_n, start, state_reg == S_IDLE)
    `CPVP_ASSERT_NEXT(a_result_holds, clk, rst_n, sts.res_valid && !res_take,
        sts.res_valid && $stable(sts.drive_value))
    `CPVP_ASSERT_IMPL(a_result_clamped, clk, rst_n, sts.res_valid,
        (sts.drive_value <= $signed({1'b0, cfg.drive_limit}))
        && (sts.drive_value >= -$signed({1'b0, cfg.drive_limit})))

endmodule

// ----- rtl/cascaded_position_velocity_pid.sv -----
// Each accepted input word yields one result word in the output register.
// No new word is taken while the controller works on a tick; the serial MAC runs seven times per tick.
// A new input word is accepted while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous) loads the default gains, limit and offset and
// clears the angle history, turn count and both error histories and sums.
// Top level: config registers, handshake and output register; uses cpvp_pkg,
// cpvp_ctrl and cpvp_mac.
module cascaded_position_velocity_pid (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic        [cpvp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [cpvp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic        [cpvp_pkg::ANGLE_W-1:0]  raw_angle,
    input  logic signed [cpvp_pkg::SPEED_W-1:0]  measured_speed,
    input  logic signed [cpvp_pkg::TARGET_W-1:0] target_angle,
    input  logic                                 hold_reset,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [cpvp_pkg::OUT_W-1:0]    drive_value,
    output logic                                 drive_enable
);

    cpvp_pkg::cfg_t      cfg_reg;
    cpvp_pkg::item_t     item;
    cpvp_pkg::ctrl_sts_t ctrl_sts;
    cpvp_pkg::mac_cmd_t  mac_cmd;
    cpvp_pkg::mac_sts_t  mac_sts;

    logic                              start;
    logic                              res_take;
    logic                              out_valid_reg;
    logic signed [cpvp_pkg::OUT_W-1:0] drive_value_reg;
    logic                              drive_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_kp      <= cpvp_pkg::GAIN_W'(cpvp_pkg::POS_KP_RST);
            cfg_reg.pos_ki      <= cpvp_pkg::GAIN_W'(cpvp_pkg::POS_KI_RST);
            cfg_reg.pos_kd      <= cpvp_pkg::GAIN_W'(cpvp_pkg::POS_KD_RST);
            cfg_reg.vel_kp      <= cpvp_pkg::GAIN_W'(cpvp_pkg::VEL_KP_RST);
            cfg_reg.vel_ki      <= cpvp_pkg::GAIN_W'(cpvp_pkg::VEL_KI_RST);
            cfg_reg.vel_kd      <= cpvp_pkg::GAIN_W'(cpvp_pkg::VEL_KD_RST);
            cfg_reg.drive_limit <= cpvp_pkg::LIMIT_W'(cpvp_pkg::DRIVE_LIMIT_RST);
            cfg_reg.zero_offset <= cpvp_pkg::OFFSET_W'(cpvp_pkg::ZERO_OFFSET_RST);
        end
        else if (cfg_write)
        begin
            unique case (cpvp_pkg::cfg_index_t'(cfg_index))
                cpvp_pkg::REG_POS_KP:      cfg_reg.pos_kp <= cfg_data[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_POS_KI:      cfg_reg.pos_ki <= cfg_data[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_POS_KD:      cfg_reg.pos_kd <= cfg_data[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_VEL_KP:      cfg_reg.vel_kp <= cfg_data[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_VEL_KI:      cfg_reg.vel_ki <= cfg_data[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_VEL_KD:      cfg_reg.vel_kd <= cfg_data[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_DRIVE_LIMIT:
                    cfg_reg.drive_limit <= cfg_data[cpvp_pkg::LIMIT_W-1:0];
                cpvp_pkg::REG_ZERO_OFFSET:
                    cfg_reg.zero_offset <= cfg_data[cpvp_pkg::OFFSET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = ctrl_sts.busy;
    assign start    = in_valid && !in_stall;

    assign item.raw_angle      = raw_angle;
    assign item.measured_speed = measured_speed;
    assign item.target_angle   = target_angle;
    assign item.hold_reset     = hold_reset;

    // The finished word moves into the output register once that slot is free.
    assign res_take = ctrl_sts.res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            drive_value_reg  <= ctrl_sts.drive_value;
            drive_enable_reg <= ctrl_sts.drive_enable;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_value  = drive_value_reg;
    assign drive_enable = drive_enable_reg;

    cpvp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .cfg      (cfg_reg),
        .res_take (res_take),
        .sts      (ctrl_sts),
        .mac_cmd  (mac_cmd),
        .mac_sts  (mac_sts)
    );

    cpvp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .sts   (mac_sts)
    );

endmodule

// ----- verif/cascaded_position_velocity_pid_tb.sv -----
// Self-checking testbench for the cascaded position/velocity controller.
// Uses cpvp_pkg for widths, register indexes and the item and register structs;
// needs the RTL of cascaded_position_velocity_pid and nothing else.
module cascaded_position_velocity_pid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpvp_pkg::*;

    localparam int     PHASE_WORDS     = 220;
    localparam int     HOLD_OFF_CYCLES = 1500;
    localparam int     WATCHDOG_LIMIT  = 8000;
    localparam int     SETTLE_CYCLES   = 200;
    localparam longint ERR_MAX         = (longint'(1) <<< 31) - 1;
    localparam longint ERR_MIN         = -(longint'(1) <<< 31);
    localparam longint TARGET_MAX      = (longint'(1) <<< (TARGET_W - 1)) - 1;
    localparam longint TARGET_MIN      = -(longint'(1) <<< (TARGET_W - 1));

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    enable;
    } drive_word_t;

    // Mirrors the controller state and registers and holds the drive words still owed.
    class drive_predictor;
        cfg_t                       regs;
        logic        [ANGLE_W-1:0]  angle_now    = '0;
        logic        [ANGLE_W-1:0]  angle_before = '0;
        logic signed [TURN_W-1:0]   turn_count   = '0;
        logic signed [ERR_W-1:0]    pos_prev     = '0;
        logic signed [ERR_W-1:0]    pos_sum      = '0;
        logic signed [EV_W-1:0]     vel_prev     = '0;
        logic signed [VSUM_W-1:0]   vel_sum      = '0;
        drive_word_t                drive_due[$];
        int                         checked      = 0;
        int                         errors       = 0;

        function new();
            regs.pos_kp      = GAIN_W'(POS_KP_RST);
            regs.pos_ki      = GAIN_W'(POS_KI_RST);
            regs.pos_kd      = GAIN_W'(POS_KD_RST);
            regs.vel_kp      = GAIN_W'(VEL_KP_RST);
            regs.vel_ki      = GAIN_W'(VEL_KI_RST);
            regs.vel_kd      = GAIN_W'(VEL_KD_RST);
            regs.drive_limit = LIMIT_W'(DRIVE_LIMIT_RST);
            regs.zero_offset = OFFSET_W'(ZERO_OFFSET_RST);
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_POS_KP:      regs.pos_kp = data[GAIN_W-1:0];
                REG_POS_KI:      regs.pos_ki = data[GAIN_W-1:0];
                REG_POS_KD:      regs.pos_kd = data[GAIN_W-1:0];
                REG_VEL_KP:      regs.vel_kp = data[GAIN_W-1:0];
                REG_VEL_KI:      regs.vel_ki = data[GAIN_W-1:0];
                REG_VEL_KD:      regs.vel_kd = data[GAIN_W-1:0];
                REG_DRIVE_LIMIT: regs.drive_limit = data[LIMIT_W-1:0];
                REG_ZERO_OFFSET: regs.zero_offset = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint position();
            return longint'(angle_now) + longint'(turn_count) * longint'(FULL_TURN)
                   - longint'($signed(regs.zero_offset));
        endfunction

        function longint integral();
            return longint'(pos_sum);
        endfunction

        // Q12.8 gains: the full-precision sum is divided by 256 toward zero, then clamped.
        function longint loop_drive(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                                    logic [GAIN_W-1:0] kd, longint e, longint s, longint d);
            longint acc;
            acc = longint'(kp) * e + longint'(ki) * s + longint'(kd) * d;
            return clip(acc / 256, -longint'(regs.drive_limit), longint'(regs.drive_limit));
        endfunction

        function void accept_word(item_t w);
            longint      swing;
            longint      aim;
            longint      err;
            longint      pos_out;
            longint      vel_err;
            longint      vel_out;
            drive_word_t due;
            // The stored angle pair is one tick old; a jump over half a turn is a wrap.
            swing = longint'(angle_now) - longint'(angle_before);
            if (swing > longint'(HALF_TURN) || swing < -longint'(HALF_TURN))
                turn_count = (swing > 0) ? turn_count - 24'sd1 : turn_count + 24'sd1;
            aim = w.hold_reset ? longint'(0) : longint'($signed(w.target_angle));
            err = clip(aim - position(), ERR_MIN, ERR_MAX);
            pos_sum = ERR_W'(clip(longint'(pos_sum) + err, ERR_MIN, ERR_MAX));
            pos_out = loop_drive(regs.pos_kp, regs.pos_ki, regs.pos_kd,
                                 err, longint'(pos_sum), err - longint'(pos_prev));
            vel_err = pos_out - longint'($signed(w.measured_speed));
            vel_sum = VSUM_W'(clip(longint'(vel_sum) + vel_err,
                                   -longint'(VEL_SUM_LIMIT), longint'(VEL_SUM_LIMIT)));
            vel_out = loop_drive(regs.vel_kp, regs.vel_ki, regs.vel_kd,
                                 vel_err, longint'(vel_sum), vel_err - longint'(vel_prev));
            vel_prev = EV_W'(vel_err);
            pos_prev = ERR_W'(err);
            angle_before = angle_now;
            angle_now = w.raw_angle;
            due.value  = w.hold_reset ? '0 : vel_out[OUT_W-1:0];
            due.enable = !w.hold_reset;
            drive_due.push_back(due);
        endfunction

        function int pending();
            return drive_due.size();
        endfunction

        task report(string what);
            errors++;
            $display("drive word %0d: %s", checked, what);
        endtask

        task check_drive(logic signed [OUT_W-1:0] value, logic enable);
            drive_word_t due;
            if (drive_due.size() == 0)
            begin
                report("arrived with nothing expected");
            end
            else
            begin
                due = drive_due.pop_front();
                if (value !== due.value)
                    report($sformatf("drive_value %0d, expected %0d", value, due.value));
                if (enable !== due.enable)
                    report($sformatf("drive_enable %b, expected %b", enable, due.enable));
            end
            checked++;
        endtask

        task flush();
            if (drive_due.size() != 0)
                report($sformatf("%0d expected words never arrived", drive_due.size()));
        endtask
    endclass

    logic                           clk            = 1'b0;
    logic                           rst_n          = 1'b0;
    logic                           cfg_write      = 1'b0;
    cfg_index_t                     cfg_index      = REG_POS_KP;
    logic        [CFG_DATA_W-1:0]   cfg_data       = '0;
    logic                           in_valid       = 1'b0;
    logic                           in_stall;
    logic        [ANGLE_W-1:0]      raw_angle      = '0;
    logic signed [SPEED_W-1:0]      measured_speed = '0;
    logic signed [TARGET_W-1:0]     target_angle   = '0;
    logic                           hold_reset     = 1'b0;
    logic                           out_valid;
    logic                           out_stall      = 1'b0;
    logic signed [OUT_W-1:0]        drive_value;
    logic                           drive_enable;

    drive_predictor drives = new();
    int             sent_words   = 0;
    int             results_seen = 0;
    int             last_raw     = 0;

    cascaded_position_velocity_pid i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_angle      (raw_angle),
        .measured_speed (measured_speed),
        .target_angle   (target_angle),
        .hold_reset     (hold_reset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_value    (drive_value),
        .drive_enable   (drive_enable)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic item_t word(int ang, int spd, longint aim, logic hold);
        item_t w;
        w.raw_angle      = ang[ANGLE_W-1:0];
        w.measured_speed = spd[SPEED_W-1:0];
        w.target_angle   = aim[TARGET_W-1:0];
        w.hold_reset     = hold;
        return w;
    endfunction

    // Mostly a shaft turning smoothly or jumping near half a turn, with a target near its position; the rest is noise.
    function automatic item_t make_word();
        int     pick;
        int     step;
        int     ang;
        longint aim;
        logic   hold;
        pick = int'($urandom_range(0, 99));
        hold = ($urandom_range(0, 11) == 0);
        if (pick < 80)
        begin
            if (pick < 70)
                step = int'($urandom_range(0, 80)) - 40;
            else
                step = int'($urandom_range(170, 190)) * (($urandom_range(0, 1) == 1) ? 1 : -1);
            ang = (last_raw % FULL_TURN + step + 2 * FULL_TURN) % FULL_TURN;
            aim = drives.position() + longint'($urandom_range(0, 4000)) - 2000;
            aim = drives.clip(aim, TARGET_MIN, TARGET_MAX);
            return word(ang, int'($urandom_range(0, 6000)) - 3000, aim, hold);
        end
        // Angles past a full turn are legal on the port and are used unchecked.
        ang = ($urandom_range(0, 7) == 0) ? int'($urandom_range(360, 511))
                                          : int'($urandom_range(0, 359));
        return word(ang, int'($urandom), longint'($urandom), hold);
    endfunction

    task automatic send_word(item_t w);
        int gap;
        gap = ((sent_words / 48) % 4 == 3) ? 0 : int'($urandom_range(0, 15));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        raw_angle      <= w.raw_angle;
        measured_speed <= w.measured_speed;
        target_angle   <= w.target_angle;
        hold_reset     <= w.hold_reset;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        drives.accept_word(w);
        sent_words++;
        last_raw = int'(w.raw_angle);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (drives.pending() != 0)
            @(posedge clk);
    endtask

    task automatic program_gains(cfg_t s);
        logic [CFG_DATA_W-1:0] vals [8];
        cfg_index_t            idx;
        vals[REG_POS_KP]      = CFG_DATA_W'(s.pos_kp);
        vals[REG_POS_KI]      = CFG_DATA_W'(s.pos_ki);
        vals[REG_POS_KD]      = CFG_DATA_W'(s.pos_kd);
        vals[REG_VEL_KP]      = CFG_DATA_W'(s.vel_kp);
        vals[REG_VEL_KI]      = CFG_DATA_W'(s.vel_ki);
        vals[REG_VEL_KD]      = CFG_DATA_W'(s.vel_kd);
        vals[REG_DRIVE_LIMIT] = CFG_DATA_W'(s.drive_limit);
        vals[REG_ZERO_OFFSET] = s.zero_offset;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            drives.set_reg(idx, vals[idx]);
            @(posedge clk);
            idx = idx.next();
        end
        cfg_write <= 1'b0;
    endtask

    // Drives a large position error until the integral reaches the goal (at most 400 words), then sends extra words.
    task automatic wind_integral(bit rising, longint goal, int extra);
        cfg_t   s;
        int     n;
        longint aim;
        s.pos_kp      = '0;
        s.pos_ki      = GAIN_W'(1);
        s.pos_kd      = '0;
        s.vel_kp      = GAIN_W'(256);
        s.vel_ki      = '0;
        s.vel_kd      = '0;
        s.drive_limit = '1;
        s.zero_offset = OFFSET_W'(rising ? TARGET_MAX : TARGET_MIN);
        aim = rising ? TARGET_MAX : TARGET_MIN;
        wait_idle();
        program_gains(s);
        n = 0;
        while ((rising ? drives.integral() < goal : drives.integral() > goal) && n < 400)
        begin
            send_word(word((last_raw % FULL_TURN + int'($urandom_range(0, 20)) + 350)
                           % FULL_TURN, int'($urandom), aim, 1'b0));
            n++;
        end
        repeat (extra)
            send_word(word(int'($urandom_range(0, 359)), int'($urandom), aim, 1'b0));
    endtask

    initial
    begin
        cfg_t s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gains: field extremes, hold, wraps in both directions and the half-turn edge.
        send_word(word(0, 0, 0, 1'b0));
        send_word(word(359, 32767, TARGET_MAX, 1'b0));
        send_word(word(0, -32768, TARGET_MIN, 1'b0));
        send_word(word(0, 0, 0, 1'b1));
        send_word(word(1, 200, 5000, 1'b1));
        send_word(word(180, 100, 0, 1'b0));
        send_word(word(0, -100, 0, 1'b0));
        send_word(word(181, 0, 0, 1'b0));
        send_word(word(0, 0, 360, 1'b0));
        send_word(word(350, 0, 0, 1'b0));
        send_word(word(10, 50, 0, 1'b0));
        send_word(word(10, 0, 0, 1'b0));
        send_word(word(350, 0, 0, 1'b0));
        send_word(word(350, -50, 0, 1'b0));
        send_word(word(360, 0, 0, 1'b0));
        send_word(word(511, 1000, 720, 1'b0));
        send_word(word(0, 0, 0, 1'b0));
        send_word(word(0, 32767, 0, 1'b0));
        send_word(word(0, -32768, 0, 1'b0));
        send_word(word(90, 0, TARGET_MAX, 1'b1));
        send_word(word(90, 0, TARGET_MIN, 1'b0));

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    s.pos_kp = GAIN_W'(512);  s.pos_ki = GAIN_W'(2);  s.pos_kd = GAIN_W'(256);
                    s.vel_kp = GAIN_W'(1024); s.vel_ki = GAIN_W'(8);  s.vel_kd = GAIN_W'(64);
                    s.drive_limit = LIMIT_W'(20000);
                    s.zero_offset = OFFSET_W'(1234);
                end
                1:
                begin
                    s.pos_kp = '1; s.pos_ki = '1; s.pos_kd = '1;
                    s.vel_kp = '1; s.vel_ki = '1; s.vel_kd = '1;
                    s.drive_limit = '1;
                    s.zero_offset = OFFSET_W'(TARGET_MAX);
                end
                2:
                begin
                    s.pos_kp = '0; s.pos_ki = '0; s.pos_kd = '0;
                    s.vel_kp = '0; s.vel_ki = '0; s.vel_kd = '0;
                    s.drive_limit = '0;
                    s.zero_offset = OFFSET_W'(TARGET_MIN);
                end
                default:
                begin
                    s.pos_kp = GAIN_W'($urandom_range(0, 8191));
                    s.pos_ki = GAIN_W'($urandom_range(0, 64));
                    s.pos_kd = GAIN_W'($urandom_range(0, 8191));
                    s.vel_kp = GAIN_W'($urandom_range(0, 8191));
                    s.vel_ki = GAIN_W'($urandom_range(0, 64));
                    s.vel_kd = GAIN_W'($urandom_range(0, 8191));
                    s.drive_limit = LIMIT_W'($urandom_range(0, 32767));
                    s.zero_offset = OFFSET_W'($urandom);
                end
            endcase
            wait_idle();
            program_gains(s);
            repeat (PHASE_WORDS)
                send_word(make_word());
        end

        // Saturate the position integral high, then low, then bring it back through zero.
        wind_integral(1'b1, ERR_MAX, 4);
        wind_integral(1'b0, ERR_MIN, 4);
        wind_integral(1'b1, 0, 0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        drives.flush();
        if (drives.errors == 0)
            $display("cascaded_position_velocity_pid regression: pass");
        else
            $display("cascaded_position_velocity_pid regression: fail");
        $finish;
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            // Twice the receiver holds off long enough for the block to back up its input.
            if (results_seen == 300 || results_seen == 1200)
                stall = HOLD_OFF_CYCLES;
            else if ((results_seen / 56) % 5 == 4)
                stall = 0;
            else
                stall = int'($urandom_range(0, 15));
            if (stall != 0)
            begin
                out_stall <= 1'b1;
                repeat (stall) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            drives.check_drive(drive_value, drive_enable);
            results_seen++;
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("cascaded_position_velocity_pid regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cpvp_pkg.sv
rtl/cpvp_mac.sv
rtl/cpvp_ctrl.sv
rtl/cascaded_position_velocity_pid.sv
verif/cascaded_position_velocity_pid_tb.sv
